FILE: hdl/ctwrm_pkg.sv
// Shared types and codes for the calendar time window rule matcher.
// No dependencies; every file of the block imports this package.
package ctwrm_pkg;

  // Item commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  // Match kinds, in priority order (lower nonzero value wins)
  localparam logic [1:0] MK_NONE    = 2'd0;
  localparam logic [1:0] MK_DATED   = 2'd1;
  localparam logic [1:0] MK_WEEKDAY = 2'd2;
  localparam logic [1:0] MK_DEFAULT = 2'd3;

  localparam logic [7:0] ANY_YEAR    = 8'd255;
  localparam logic [2:0] ANY_WEEKDAY = 3'd7;

  localparam int unsigned MinW = 11;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] year_code;
    logic [3:0] month_num;
    logic [4:0] day_num;
    logic [2:0] weekday_code;
    logic [4:0] opening_hour;
    logic [5:0] open_minute;
    logic [4:0] closing_hour;
    logic [5:0] close_minute;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } in_item_t;

  typedef struct packed {
    logic            unlocked;
    logic [MinW-1:0] minutes_to_open;
    logic [MinW-1:0] minutes_to_close;
    logic [1:0]      match_kind;
    logic            state_changed;
    logic            table_full;
  } out_item_t;

  // One stored rule, 42 bits
  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] open_h;
    logic [5:0] open_m;
    logic [4:0] close_h;
    logic [5:0] close_m;
  } rule_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOW,
    ST_SCAN,
    ST_OPEN,
    ST_CLOSE,
    ST_FINISH
  } state_e;

endpackage

FILE: hdl/calendar_time_window_rule_matcher.sv
// Top level of the calendar time window rule matcher: rule memory, scan
// sequencer and shared minute unit. Depends on ctwrm_pkg.
//
// Keeps up to RULE_SLOTS schedule rules in a single-port memory and
// handles one item at a time. A clear, add or unused item goes straight
// to the finish state and posts its result to the output register from
// there. An evaluate item first converts the current time, then scans
// every stored rule (plus the registered memory read and the end-of-scan
// check), then runs open and close through the minute unit when a rule
// matched, and finally posts the result to the output register. The scan
// length is set by the one rule read per cycle from the rule memory, the
// tail by the single shared minute unit (hour*60+minute, then subtract and
// compare against now). in_stall_o is high from acceptance until the result
// is posted to the output register, so the next item is taken only after
// posting; the output register holds a finished result until taken, while
// the next item may already be accepted. There is no clearing pass: only
// rules below the fill count are ever read.
module calendar_time_window_rule_matcher #(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ctwrm_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ctwrm_pkg::out_item_t out_item_o
);
  import ctwrm_pkg::*;

  localparam int unsigned CW = $clog2(RULE_SLOTS + 1);
  localparam int unsigned IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam logic [CW-1:0] SlotsC = CW'(RULE_SLOTS);

  // Control state
  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   scan_idx_q, scan_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic            last_unl_q, last_unl_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      best_kind_q, best_kind_d;

  // Item context and partial results
  logic [1:0]      cmd_q, cmd_d;
  logic [7:0]      yr_q, yr_d;
  logic [3:0]      mo_q, mo_d;
  logic [4:0]      dy_q, dy_d;
  logic [2:0]      wd_q, wd_d;
  logic [4:0]      nowh_q, nowh_d;
  logic [5:0]      nowm_q, nowm_d;
  logic [MinW-1:0] now_q, now_d;
  rule_t           best_rule_q, best_rule_d;
  logic            open_ok_q, open_ok_d;
  logic            unl_q, unl_d;
  logic [MinW-1:0] mto_q, mto_d;
  logic [MinW-1:0] mtc_q, mtc_d;
  logic            full_q, full_d;
  out_item_t       out_item_q, out_item_d;

  // Rule memory
  rule_t           mem_q [RULE_SLOTS];
  rule_t           rd_data_q;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  rule_t           wr_data;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;

  // Shared minute unit: t = h*60 + m, compared against base
  logic [4:0]      mu_h;
  logic [5:0]      mu_m;
  logic [MinW-1:0] mu_base;
  logic [MinW-1:0] mu_t;
  logic [MinW-1:0] mu_diff;
  logic            mu_gt;
  logic            mu_ge;

  // Candidate class of the rule just read
  logic [1:0]      cand_kind;
  logic            out_free;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    mu_t    = ({mu_h, 6'b0} - {4'b0, mu_h, 2'b0}) + {5'b0, mu_m};
    mu_diff = mu_t - mu_base;
    mu_gt   = mu_t > mu_base;
    mu_ge   = mu_t >= mu_base;
  end

  always_comb begin
    cand_kind = MK_NONE;
    if (rd_data_q.year != ANY_YEAR && rd_data_q.year == yr_q &&
        rd_data_q.month == mo_q && rd_data_q.day == dy_q) begin
      cand_kind = MK_DATED;
    end else if (rd_data_q.weekday != ANY_WEEKDAY && rd_data_q.weekday == wd_q) begin
      cand_kind = MK_WEEKDAY;
    end else if (rd_data_q.weekday == ANY_WEEKDAY && rd_data_q.year == ANY_YEAR) begin
      cand_kind = MK_DEFAULT;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    rd_vld_d    = 1'b0;
    last_unl_d  = last_unl_q;
    out_valid_d = out_valid_q && out_stall_i;
    best_kind_d = best_kind_q;
    cmd_d       = cmd_q;
    yr_d        = yr_q;
    mo_d        = mo_q;
    dy_d        = dy_q;
    wd_d        = wd_q;
    nowh_d      = nowh_q;
    nowm_d      = nowm_q;
    now_d       = now_q;
    best_rule_d = best_rule_q;
    open_ok_d   = open_ok_q;
    unl_d       = unl_q;
    mto_d       = mto_q;
    mtc_d       = mtc_q;
    full_d      = full_q;
    out_item_d  = out_item_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IW-1:0];
    wr_data     = rule_t'({in_item_i.year_code, in_item_i.month_num, in_item_i.day_num,
                           in_item_i.weekday_code, in_item_i.opening_hour,
                           in_item_i.open_minute, in_item_i.closing_hour,
                           in_item_i.close_minute});
    rd_en       = 1'b0;
    rd_addr     = scan_idx_q[IW-1:0];
    mu_h        = nowh_q;
    mu_m        = nowm_q;
    mu_base     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // Latch the item and clear the partial result
          cmd_d       = in_item_i.command;
          yr_d        = in_item_i.year_code;
          mo_d        = in_item_i.month_num;
          dy_d        = in_item_i.day_num;
          wd_d        = in_item_i.weekday_code;
          nowh_d      = in_item_i.now_hour;
          nowm_d      = in_item_i.now_minute;
          best_kind_d = MK_NONE;
          unl_d       = 1'b0;
          mto_d       = '0;
          mtc_d       = '0;
          full_d      = 1'b0;
          state_d     = ST_FINISH;
          case (in_item_i.command)
            CMD_CLEAR: count_d = '0;
            CMD_ADD: begin
              if (count_q >= SlotsC) begin
                full_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_EVAL: state_d = ST_NOW;
            default: ;
          endcase
        end
      end
      ST_NOW: begin
        // Convert the current time to minutes
        now_d      = mu_diff;
        scan_idx_d = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        // Issue one read per cycle; judge the rule read last cycle
        if (scan_idx_q < count_q) begin
          rd_en      = 1'b1;
          rd_vld_d   = 1'b1;
          scan_idx_d = scan_idx_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (cand_kind != MK_NONE &&
              (best_kind_q == MK_NONE || cand_kind < best_kind_q)) begin
            best_kind_d = cand_kind;
            best_rule_d = rd_data_q;
          end
        end else if (scan_idx_q == count_q) begin
          state_d = (best_kind_q != MK_NONE) ? ST_OPEN : ST_FINISH;
        end
      end
      ST_OPEN: begin
        mu_h      = best_rule_q.open_h;
        mu_m      = best_rule_q.open_m;
        mu_base   = now_q;
        mto_d     = mu_gt ? mu_diff : '0;
        open_ok_d = !mu_gt;
        state_d   = ST_CLOSE;
      end
      ST_CLOSE: begin
        mu_h    = best_rule_q.close_h;
        mu_m    = best_rule_q.close_m;
        mu_base = now_q;
        mtc_d   = mu_gt ? mu_diff : '0;
        unl_d   = open_ok_q && mu_ge;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // Post the result once the output register is free
        if (out_free) begin
          out_item_d.unlocked         = unl_q;
          out_item_d.minutes_to_open  = mto_q;
          out_item_d.minutes_to_close = mtc_q;
          out_item_d.match_kind       = best_kind_q;
          out_item_d.state_changed    = 1'b0;
          out_item_d.table_full       = full_q;
          if (cmd_q == CMD_EVAL) begin
            out_item_d.state_changed = unl_q != last_unl_q;
            last_unl_d               = unl_q;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      last_unl_q  <= 1'b0;
      out_valid_q <= 1'b0;
      best_kind_q <= MK_NONE;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      rd_vld_q    <= rd_vld_d;
      last_unl_q  <= last_unl_d;
      out_valid_q <= out_valid_d;
      best_kind_q <= best_kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    yr_q        <= yr_d;
    mo_q        <= mo_d;
    dy_q        <= dy_d;
    wd_q        <= wd_d;
    nowh_q      <= nowh_d;
    nowm_q      <= nowm_d;
    now_q       <= now_d;
    best_rule_q <= best_rule_d;
    open_ok_q   <= open_ok_d;
    unl_q       <= unl_d;
    mto_q       <= mto_d;
    mtc_q       <= mtc_d;
    full_q      <= full_d;
    out_item_q  <= out_item_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SlotsC)
    else $error("rule count exceeds table size");

  // An accepted item always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted item dropped");

  // Memory read data is only judged while scanning
  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == ST_SCAN)
    else $error("rule read outside scan");

  // Unlocked needs a matched rule and an opening time already reached
  a_unlock_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.unlocked |->
      out_item_o.match_kind != MK_NONE && out_item_o.minutes_to_open == '0)
    else $error("unlocked without a matching open window");
`endif

endmodule
